/* hdl/eased_color_fade_unit_defines.svh */
// Assertion macros for the eased colour fade unit.
// Included by the top level; no other dependencies.
`ifndef EASED_COLOR_FADE_UNIT_DEFINES_SVH
`define EASED_COLOR_FADE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define EFU_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define EFU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EFU_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define EFU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* hdl/efu_pkg.sv */
// Shared types and constants for the eased colour fade unit.
// No dependencies; used by efu_seq and eased_color_fade_unit.
`timescale 1ns / 1ps

package efu_pkg;

  // fixed field widths of the beats
  localparam int CHAN_W   = 16;
  localparam int DELTA_W  = 16;
  localparam int LEN_W    = 24;

  // default storage widths
  localparam int COLOR_BITS_DEF = 16;
  localparam int TIME_BITS_DEF  = 24;

  // channel count and fraction width
  localparam int NCH  = 4;
  localparam int CH_W = 2;
  localparam int QW   = 17;          // Q1.16 fraction incl. the value one
  localparam int CNT_W = 5;          // holds QW-1
  localparam logic [QW-1:0] ONE_Q16 = 17'h10000;

  // mode codes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_SET   = 2'd2;

  // program counter
  localparam int PC_W = 4;

  typedef struct packed {
    logic [1:0]         mode;
    logic [DELTA_W-1:0] delta_time;
    logic [CHAN_W-1:0]  target_red;
    logic [CHAN_W-1:0]  target_green;
    logic [CHAN_W-1:0]  target_blue;
    logic [CHAN_W-1:0]  target_alpha;
    logic [LEN_W-1:0]   fade_length;
  } in_beat_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_alpha;
    logic              done_res;
    logic              visible;
  } out_beat_t;

  // datapath operations driven by the microcode
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_LOAD,
    OP_ADD_TIMER,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SQUARE,
    OP_CUBE,
    OP_BLEND_MUL,
    OP_BLEND_WB,
    OP_EMIT
  } op_t;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NO_BEAT,
    COND_IS_TICK,
    COND_FINISHED,
    COND_CNT_NZ,
    COND_CH_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic is_tick;
    logic finished;
    logic cnt_nz;
    logic ch_more;
    logic out_busy;
  } stat_t;

endpackage

/* hdl/efu_seq.sv */
// Microcode sequencer for the eased colour fade unit: step counter,
// read-only program and jump logic. Depends on efu_pkg.
`timescale 1ns / 1ps

module efu_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  efu_pkg::stat_t stat,
  output efu_pkg::op_t  op
);

  // program addresses
  localparam logic [efu_pkg::PC_W-1:0] PC_IDLE   = 4'd0;
  localparam logic [efu_pkg::PC_W-1:0] PC_TICK   = 4'd3;
  localparam logic [efu_pkg::PC_W-1:0] PC_DIV    = 4'd6;
  localparam logic [efu_pkg::PC_W-1:0] PC_BLEND  = 4'd9;
  localparam logic [efu_pkg::PC_W-1:0] PC_EMIT   = 4'd11;
  localparam logic [efu_pkg::PC_W-1:0] PC_LAST   = 4'd11;

  logic [efu_pkg::PC_W-1:0] pc_r, pc_nxt;
  efu_pkg::ucode_t          uw;
  logic                     take;

  // control store
  always_comb begin
    case (pc_r)
      4'd0:    uw = '{efu_pkg::OP_ACCEPT,    efu_pkg::COND_NO_BEAT,  PC_IDLE};
      4'd1:    uw = '{efu_pkg::OP_NOP,       efu_pkg::COND_IS_TICK,  PC_TICK};
      4'd2:    uw = '{efu_pkg::OP_LOAD,      efu_pkg::COND_ALWAYS,   PC_EMIT};
      4'd3:    uw = '{efu_pkg::OP_NOP,       efu_pkg::COND_FINISHED, PC_EMIT};
      4'd4:    uw = '{efu_pkg::OP_ADD_TIMER, efu_pkg::COND_NONE,     PC_IDLE};
      4'd5:    uw = '{efu_pkg::OP_DIV_INIT,  efu_pkg::COND_NONE,     PC_IDLE};
      4'd6:    uw = '{efu_pkg::OP_DIV_STEP,  efu_pkg::COND_CNT_NZ,   PC_DIV};
      4'd7:    uw = '{efu_pkg::OP_SQUARE,    efu_pkg::COND_NONE,     PC_IDLE};
      4'd8:    uw = '{efu_pkg::OP_CUBE,      efu_pkg::COND_NONE,     PC_IDLE};
      4'd9:    uw = '{efu_pkg::OP_BLEND_MUL, efu_pkg::COND_NONE,     PC_IDLE};
      4'd10:   uw = '{efu_pkg::OP_BLEND_WB,  efu_pkg::COND_CH_MORE,  PC_BLEND};
      4'd11:   uw = '{efu_pkg::OP_EMIT,      efu_pkg::COND_OUT_BUSY, PC_EMIT};
      default: uw = '{efu_pkg::OP_NOP,       efu_pkg::COND_ALWAYS,   PC_IDLE};
    endcase
  end

  // jump condition select
  always_comb begin
    case (uw.cond)
      efu_pkg::COND_NONE:     take = 1'b0;
      efu_pkg::COND_ALWAYS:   take = 1'b1;
      efu_pkg::COND_NO_BEAT:  take = !stat.in_valid;
      efu_pkg::COND_IS_TICK:  take = stat.is_tick;
      efu_pkg::COND_FINISHED: take = stat.finished;
      efu_pkg::COND_CNT_NZ:   take = stat.cnt_nz;
      efu_pkg::COND_CH_MORE:  take = stat.ch_more;
      efu_pkg::COND_OUT_BUSY: take = stat.out_busy;
      default:                take = 1'b0;
    endcase
  end

  // next step: jump, wrap at end of program, or fall through
  always_comb begin
    if (take) begin
      pc_nxt = uw.target;
    end else if (pc_r == PC_LAST) begin
      pc_nxt = PC_IDLE;
    end else begin
      pc_nxt = pc_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign op = uw.op;

endmodule

/* hdl/eased_color_fade_unit.sv */
// Top level of the eased colour fade unit: datapath with serial divider,
// shared multiplier and colour state. Depends on efu_pkg, efu_seq and
// eased_color_fade_unit_defines.svh.
//
//   channel  ports                      direction  beat
//   input    in_valid/in_ready/in_data  in         one command (tick, start, set)
//   result   out_valid/out_ready/out_data  out     colour, done and visible flags
//
// One beat is taken at a time. Start, set, unused and finished ticks go from
// the accept step through a load or finish check straight to the output step.
// An active tick runs timer update and divider set-up, 17 steps of the
// restoring divider for the fraction, two multiply steps for the cube, then
// two steps per channel on the shared blend multiplier. Reset is synchronous
// and clears the colours and the timer, so the unit starts finished and
// invisible. A stalled result holds the sequencer at its output step; no new
// beat is taken until it leaves.
`timescale 1ns / 1ps
`include "eased_color_fade_unit_defines.svh"

module eased_color_fade_unit #(
  parameter int COLOR_BITS = efu_pkg::COLOR_BITS_DEF,
  parameter int TIME_BITS  = efu_pkg::TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  efu_pkg::in_beat_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output efu_pkg::out_beat_t out_data
);

  localparam int SUM_W = ((TIME_BITS > efu_pkg::DELTA_W) ? TIME_BITS : efu_pkg::DELTA_W) + 1;
  localparam int MUL_W = COLOR_BITS + efu_pkg::QW;
  localparam int NCH   = efu_pkg::NCH;
  localparam int QW    = efu_pkg::QW;
  localparam logic [QW-1:0] ONE_Q16_F = efu_pkg::ONE_Q16;

  efu_pkg::op_t   op;
  efu_pkg::stat_t stat;

  // architectural state
  logic [COLOR_BITS-1:0] cur_r   [NCH];
  logic [COLOR_BITS-1:0] cur_nxt [NCH];
  logic [COLOR_BITS-1:0] start_r   [NCH];
  logic [COLOR_BITS-1:0] start_nxt [NCH];
  logic [COLOR_BITS-1:0] goal_r   [NCH];
  logic [COLOR_BITS-1:0] goal_nxt [NCH];
  logic [TIME_BITS-1:0]  elapsed_r, elapsed_nxt;
  logic [TIME_BITS-1:0]  span_r, span_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // working registers
  efu_pkg::in_beat_t     item_r, item_nxt;
  logic [TIME_BITS:0]    rem_r, rem_nxt;
  logic [QW-1:0]         q_r, q_nxt;
  logic [efu_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2*QW-2:0]       sq_r, sq_nxt;
  logic [QW-1:0]         eased_r, eased_nxt;
  logic [efu_pkg::CH_W-1:0] ch_r, ch_nxt;
  logic [MUL_W-1:0]      mul_r, mul_nxt;
  logic                  up_r, up_nxt;
  efu_pkg::out_beat_t    out_r, out_nxt;

  // combinational helpers
  logic [COLOR_BITS-1:0] tgt [NCH];
  logic [TIME_BITS-1:0]  len;
  logic [SUM_W-1:0]      sum;
  logic                  ge;
  logic [TIME_BITS:0]    rem_sub;
  logic [QW-1:0]         u;
  logic [3*QW-3:0]       cube_prod;
  logic [QW-1:0]         cube;
  logic [COLOR_BITS-1:0] from_c, to_c, diff;
  logic [COLOR_BITS-1:0] step;
  logic                  out_busy;

  efu_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  assign out_busy = out_valid_r && !out_ready;
  assign in_ready = rst_n && (op == efu_pkg::OP_ACCEPT);

  // status back to the sequencer
  always_comb begin
    stat.in_valid = in_valid;
    stat.is_tick  = (item_r.mode == efu_pkg::MODE_TICK);
    stat.finished = !(elapsed_r < span_r);
    stat.cnt_nz   = (cnt_r != '0);
    stat.ch_more  = (ch_r != efu_pkg::CH_W'(NCH - 1));
    stat.out_busy = out_busy;
  end

  // operand shaping
  assign tgt[0] = COLOR_BITS'(item_r.target_red);
  assign tgt[1] = COLOR_BITS'(item_r.target_green);
  assign tgt[2] = COLOR_BITS'(item_r.target_blue);
  assign tgt[3] = COLOR_BITS'(item_r.target_alpha);
  assign len    = TIME_BITS'(item_r.fade_length);
  assign sum    = SUM_W'(elapsed_r) + SUM_W'(item_r.delta_time);

  // one restoring divider step
  assign ge      = (rem_r >= {1'b0, span_r});
  assign rem_sub = ge ? (rem_r - {1'b0, span_r}) : rem_r;

  // ease curve operands
  assign u         = ONE_Q16_F - q_r;
  assign cube_prod = sq_r * u;
  assign cube      = cube_prod[3*QW-3:2*QW-2];

  // blend operands for the selected channel
  assign from_c = start_r[ch_r];
  assign to_c   = goal_r[ch_r];
  assign diff   = (to_c >= from_c) ? (to_c - from_c) : (from_c - to_c);
  assign step   = COLOR_BITS'(mul_r >> (QW - 1));

  // next state per microcode operation
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      cur_nxt[i]   = cur_r[i];
      start_nxt[i] = start_r[i];
      goal_nxt[i]  = goal_r[i];
    end
    elapsed_nxt   = elapsed_r;
    span_nxt      = span_r;
    out_valid_nxt = out_valid_r && !out_ready;
    item_nxt      = item_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    sq_nxt        = sq_r;
    eased_nxt     = eased_r;
    ch_nxt        = ch_r;
    mul_nxt       = mul_r;
    up_nxt        = up_r;
    out_nxt       = out_r;

    case (op)
      efu_pkg::OP_ACCEPT: begin
        if (in_valid) begin
          item_nxt = in_data;
        end
      end
      efu_pkg::OP_LOAD: begin
        if (item_r.mode == efu_pkg::MODE_START && len != '0) begin
          for (int i = 0; i < NCH; i++) begin
            start_nxt[i] = cur_r[i];
            goal_nxt[i]  = tgt[i];
          end
          span_nxt    = len;
          elapsed_nxt = '0;
        end else if (item_r.mode == efu_pkg::MODE_START ||
                     item_r.mode == efu_pkg::MODE_SET) begin
          // zero-length start or set: force the colour
          for (int i = 0; i < NCH; i++) begin
            cur_nxt[i]   = tgt[i];
            start_nxt[i] = tgt[i];
            goal_nxt[i]  = tgt[i];
          end
          span_nxt    = '0;
          elapsed_nxt = '0;
        end
      end
      efu_pkg::OP_ADD_TIMER: begin
        elapsed_nxt = (sum > SUM_W'(span_r)) ? span_r : TIME_BITS'(sum);
      end
      efu_pkg::OP_DIV_INIT: begin
        rem_nxt = {1'b0, elapsed_r};
        q_nxt   = '0;
        cnt_nxt = efu_pkg::CNT_W'(QW - 1);
      end
      efu_pkg::OP_DIV_STEP: begin
        rem_nxt = {rem_sub[TIME_BITS-1:0], 1'b0};
        q_nxt   = {q_r[QW-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
      end
      efu_pkg::OP_SQUARE: begin
        sq_nxt = (2*QW-1)'(u) * (2*QW-1)'(u);
      end
      efu_pkg::OP_CUBE: begin
        eased_nxt = ONE_Q16_F - cube;
        ch_nxt    = '0;
      end
      efu_pkg::OP_BLEND_MUL: begin
        mul_nxt = MUL_W'(diff) * MUL_W'(eased_r);
        up_nxt  = (to_c >= from_c);
      end
      efu_pkg::OP_BLEND_WB: begin
        cur_nxt[ch_r] = up_r ? (from_c + step) : (from_c - step);
        ch_nxt        = ch_r + 1'b1;
      end
      efu_pkg::OP_EMIT: begin
        if (!out_busy) begin
          out_valid_nxt     = 1'b1;
          out_nxt.out_red   = efu_pkg::CHAN_W'(cur_r[0]);
          out_nxt.out_green = efu_pkg::CHAN_W'(cur_r[1]);
          out_nxt.out_blue  = efu_pkg::CHAN_W'(cur_r[2]);
          out_nxt.out_alpha = efu_pkg::CHAN_W'(cur_r[3]);
          out_nxt.done_res  = !(elapsed_r < span_r);
          out_nxt.visible   = (cur_r[3] != '0);
        end
      end
      default: begin
      end
    endcase
  end

  // state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCH; i++) begin
        cur_r[i]   <= '0;
        start_r[i] <= '0;
        goal_r[i]  <= '0;
      end
      elapsed_r   <= '0;
      span_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < NCH; i++) begin
        cur_r[i]   <= cur_nxt[i];
        start_r[i] <= start_nxt[i];
        goal_r[i]  <= goal_nxt[i];
      end
      elapsed_r   <= elapsed_nxt;
      span_r      <= span_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    cnt_r   <= cnt_nxt;
    sq_r    <= sq_nxt;
    eased_r <= eased_nxt;
    ch_r    <= ch_nxt;
    mul_r   <= mul_nxt;
    up_r    <= up_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  `EFU_ASSERT_NEXT(a_one_beat, clk, rst_n, in_valid && in_ready, !in_ready, "second beat taken")
  `EFU_ASSERT_SAME(a_timer_le_span, clk, rst_n, 1'b1, elapsed_r <= span_r, "timer beyond duration")
  `EFU_ASSERT_SAME(a_frac_range, clk, rst_n, op == efu_pkg::OP_SQUARE, q_r <= ONE_Q16_F, "fraction above one")
  `EFU_ASSERT_SAME(a_rem_range, clk, rst_n, op == efu_pkg::OP_DIV_STEP, (rem_r <= {span_r, 1'b0}), "remainder too big")

endmodule
